@@ hw/rtl/fhc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhc_pkg
// Shared types and codes for the fan hysteresis controller.
// ----------------------------------------------------------------------------
package fhc_pkg;

    localparam int TEMP_W      = 12;
    localparam int MARGIN_W    = 8;
    localparam int LIMIT_W     = 4;
    localparam int MODE_W      = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 8;

    // Release threshold needs room for threshold minus margin
    localparam int CMP_W = TEMP_W + 2;

    localparam logic [LIMIT_W-1:0] COUNT_MAX = {LIMIT_W{1'b1}};

    // Control mode codes
    localparam logic [MODE_W-1:0] MODE_SELF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOTE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EITHER = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CONTROL_MODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ON_THRESHOLD   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_MARGIN = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FAULT_LIMIT    = 2'd3;

    // Configuration reset values
    localparam logic [MODE_W-1:0]          RST_CONTROL_MODE   = MODE_REMOTE;
    localparam logic signed [TEMP_W-1:0]   RST_ON_THRESHOLD   = 12'sd450;
    localparam logic [MARGIN_W-1:0]        RST_RELEASE_MARGIN = 8'd30;
    localparam logic [LIMIT_W-1:0]         RST_FAULT_LIMIT    = 4'd3;

    typedef enum logic [1:0] {
        SEQ_OFF     = 2'd0,
        SEQ_ON      = 2'd1,
        SEQ_RUNNING = 2'd2
    } seq_state_t;

    typedef struct packed {
        logic [MODE_W-1:0]        control_mode;
        logic signed [TEMP_W-1:0] on_threshold;
        logic [MARGIN_W-1:0]      release_margin;
        logic [LIMIT_W-1:0]       fault_limit;
    } cfg_t;

    typedef struct packed {
        logic                     remote_cmd;
        logic                     fan_feedback;
        logic signed [TEMP_W-1:0] cell_temp_max;
    } item_t;

    typedef struct packed {
        logic       feedback_echo;
        logic [1:0] sequence_res;
        logic       fault;
        logic       fan_output;
        logic       low_switch;
        logic       high_switch;
    } result_t;

endpackage

@@ hw/rtl/fhc_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhc_cfg
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module fhc_cfg
    import fhc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg        = cfg_reg;

    // Decode the register index of a write transfer
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CONTROL_MODE:   cfg_next.control_mode   = cfg_data[MODE_W-1:0];
                REG_ON_THRESHOLD:   cfg_next.on_threshold   = $signed(cfg_data[TEMP_W-1:0]);
                REG_RELEASE_MARGIN: cfg_next.release_margin = cfg_data[MARGIN_W-1:0];
                REG_FAULT_LIMIT:    cfg_next.fault_limit    = cfg_data[LIMIT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.control_mode   <= RST_CONTROL_MODE;
            cfg_reg.on_threshold   <= RST_ON_THRESHOLD;
            cfg_reg.release_margin <= RST_RELEASE_MARGIN;
            cfg_reg.fault_limit    <= RST_FAULT_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hw/rtl/fhc_in_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhc_in_reg
// Input register stage; refills in the same cycle the core takes its item.
// ----------------------------------------------------------------------------
module fhc_in_reg
    import fhc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  item_valid,
    input  logic  item_take,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Accept when empty or when the held item leaves this cycle
    assign in_ready   = !valid_reg || item_take;
    assign valid_next = in_ready ? in_valid : valid_reg;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on an input transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

@@ hw/rtl/fhc_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhc_core
// Sequencer, fault counter and result register; one tick per cycle unless stalled.
// ----------------------------------------------------------------------------
module fhc_core
    import fhc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    item_valid,
    output logic    item_take,
    input  item_t   item,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    seq_state_t        seq_reg, seq_next;
    logic              fault_reg, fault_next;
    logic [LIMIT_W-1:0] count_reg, count_next;
    logic              fan_reg, fan_next;
    logic              high_reg, high_next;
    logic              low_reg, low_next;
    logic              res_valid_reg, res_valid_next;
    result_t           res_reg, res_next;

    logic signed [CMP_W-1:0] temp_ext;
    logic signed [CMP_W-1:0] thr_ext;
    logic signed [CMP_W-1:0] release_level;
    logic                    hot;
    logic                    cool;
    logic                    go;
    logic                    rel;
    logic [LIMIT_W-1:0]      limit_m1;
    logic [LIMIT_W-1:0]      count_inc;

    // Take an item when the result register is free or drains this cycle
    assign item_take = item_valid && (!res_valid_reg || res_ready);

    // Temperature compares at full precision
    assign temp_ext      = CMP_W'(item.cell_temp_max);
    assign thr_ext       = CMP_W'(cfg.on_threshold);
    assign release_level = thr_ext - $signed({{(CMP_W-MARGIN_W){1'b0}}, cfg.release_margin});
    assign hot           = temp_ext >= thr_ext;
    assign cool          = temp_ext < release_level;

    assign limit_m1  = cfg.fault_limit - LIMIT_W'(1);
    assign count_inc = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + LIMIT_W'(1);

    // Mode selects the turn-on and release rules; mode three has none
    always_comb
    begin
        case (cfg.control_mode)
            MODE_SELF:
            begin
                go  = hot;
                rel = cool;
            end
            MODE_REMOTE:
            begin
                go  = item.remote_cmd;
                rel = !item.remote_cmd;
            end
            MODE_EITHER:
            begin
                go  = hot || item.remote_cmd;
                rel = cool && !item.remote_cmd;
            end
            default:
            begin
                go  = 1'b0;
                rel = 1'b0;
            end
        endcase
    end

    // Next state for one tick
    always_comb
    begin
        seq_next   = seq_reg;
        fault_next = fault_reg;
        count_next = count_reg;
        fan_next   = fan_reg;
        high_next  = high_reg;
        low_next   = low_reg;
        if (!fault_reg)
        begin
            unique case (seq_reg)
                SEQ_OFF:
                begin
                    high_next = 1'b1;
                    if (go)
                    begin
                        seq_next = SEQ_ON;
                    end
                end
                SEQ_ON:
                begin
                    low_next = 1'b1;
                    fan_next = 1'b1;
                    seq_next = SEQ_RUNNING;
                end
                SEQ_RUNNING:
                begin
                    if (rel)
                    begin
                        seq_next = SEQ_OFF;
                        low_next = 1'b0;
                        fan_next = 1'b0;
                    end
                    else if (!item.fan_feedback)
                    begin
                        // Count up, latch the fault once the count reaches limit minus one
                        if (count_inc >= limit_m1)
                        begin
                            count_next = '0;
                            fault_next = 1'b1;
                        end
                        else
                        begin
                            count_next = count_inc;
                        end
                    end
                    else if (count_reg != '0)
                    begin
                        count_next = count_reg - LIMIT_W'(1);
                    end
                end
                default:
                begin
                    seq_next = seq_reg;
                end
            endcase
        end
        else
        begin
            // Latched fault drives everything off
            seq_next  = SEQ_OFF;
            fan_next  = 1'b0;
            low_next  = 1'b0;
            high_next = 1'b0;
        end
    end

    // Result register contents
    always_comb
    begin
        res_next.high_switch   = high_next;
        res_next.low_switch    = low_next;
        res_next.fan_output    = fan_next;
        res_next.fault         = fault_next;
        res_next.sequence_res  = seq_next;
        res_next.feedback_echo = item.fan_feedback;
        if (item_take)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // Advance control state on each tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= SEQ_OFF;
            fault_reg     <= 1'b0;
            count_reg     <= '0;
            fan_reg       <= 1'b0;
            high_reg      <= 1'b1;
            low_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (item_take)
            begin
                seq_reg   <= seq_next;
                fault_reg <= fault_next;
                count_reg <= count_next;
                fan_reg   <= fan_next;
                high_reg  <= high_next;
                low_reg   <= low_next;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    a_fault_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        fault_reg |=> fault_reg)
        else $error("fault flag cleared without reset");

    // The tick after the fault latches drives everything off
    a_fault_all_off: assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && fault_reg) |=>
        (res_valid_reg && !res_reg.high_switch && !res_reg.low_switch &&
         !res_reg.fan_output))
        else $error("tick after the fault latch with a switch still driven");

    a_fan_follows_low: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.fan_output == res_reg.low_switch))
        else $error("fan output and low-side drive disagree");

    a_running_low_on: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == SEQ_RUNNING) |-> (low_reg && fan_reg))
        else $error("running without low-side drive");
`endif

endmodule

@@ hw/rtl/fan_hysteresis_controller_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_hysteresis_controller_top
// Fan sequencer with temperature hysteresis, remote command and fault latch.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the s_ side is one tick: hottest cell temperature,
//   fan feedback and remote command. Each tick yields exactly one transfer
//   on the m_ side with the switch drives, fan output, fault flag,
//   sequencer state and the echoed feedback after that tick.
//   The cfg_ channel writes the four control registers by index; it is
//   always ready and writes take effect from the next tick.
//   Path: an accepted tick waits in the input register, then its result
//   sits in the result register until it is taken on the m_ side.
//   Throughput: one tick per clock unless stalled, set by the single input
//   register to result register pass of the sequencer and fault counter.
//   Stall: if m_tready is low the result register holds, the input register
//   takes one more tick, then s_tready drops until the result is taken.
//   Reset: sequencer off, high-side switch on, low side and fan off, fault
//   and counter cleared, registers at their defaults, both pipe stages empty.
// ----------------------------------------------------------------------------
module fan_hysteresis_controller_top
    import fhc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [11:0] cell_temp_max, [12] fan_feedback, [13] remote_cmd, [15:14] zero
    input  logic [S_TDATA_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] high_switch, [1] low_switch, [2] fan_output, [3] fault,
    // [5:4] sequence_res, [6] feedback_echo, [7] zero
    output logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg;
    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    item_take;
    result_t res;

    // Unpack the input transfer
    assign in_item.cell_temp_max = $signed(s_tdata[TEMP_W-1:0]);
    assign in_item.fan_feedback  = s_tdata[TEMP_W];
    assign in_item.remote_cmd    = s_tdata[TEMP_W+1];

    fhc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fhc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    fhc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    // Pack the result, zero fill to a whole byte
    assign m_tdata = {{(M_TDATA_W-$bits(result_t)){1'b0}}, res};

endmodule

@@ tb/fan_hysteresis_controller_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_hysteresis_controller_checker
// Watches the tick, result and register channels, keeps its own copy of the
// sequencer, fault counter and registers, and compares every result transfer
// field by field with the oldest predicted drive set.
// ----------------------------------------------------------------------------
module fan_hysteresis_controller_checker
    import fhc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending
);

    // Shadow registers and controller state
    cfg_t               regs_m;
    seq_state_t         seq_m;
    logic               latched_m;
    logic [LIMIT_W-1:0] count_m;
    logic               fan_on_m;
    logic               high_m;
    logic               low_m;

    result_t            expected_drives[$];
    result_t            exp_r;
    result_t            got_r;

    // Advance the shadow controller by one tick and return its drive set
    function automatic result_t next_fan_drives(input item_t tick);
        int                 temp_v;
        int                 thr_v;
        int                 release_v;
        logic               hot;
        logic               cool;
        logic               turn_on;
        logic               let_go;
        logic [LIMIT_W-1:0] trip_at;
        result_t            res;
        temp_v    = $signed(tick.cell_temp_max);
        thr_v     = $signed(regs_m.on_threshold);
        release_v = thr_v - int'(regs_m.release_margin);
        hot       = (temp_v >= thr_v);
        cool      = (temp_v < release_v);
        turn_on   = 1'b0;
        let_go    = 1'b0;
        if (!latched_m) begin
            case (seq_m)
                SEQ_OFF:
                begin
                    high_m = 1'b1;
                    case (regs_m.control_mode)
                        MODE_SELF:   turn_on = hot;
                        MODE_REMOTE: turn_on = tick.remote_cmd;
                        MODE_EITHER: turn_on = hot | tick.remote_cmd;
                        default:     turn_on = 1'b0;
                    endcase
                    if (turn_on)
                        seq_m = SEQ_ON;
                end
                SEQ_ON:
                begin
                    low_m    = 1'b1;
                    fan_on_m = 1'b1;
                    seq_m    = SEQ_RUNNING;
                end
                SEQ_RUNNING:
                begin
                    case (regs_m.control_mode)
                        MODE_SELF:   let_go = cool;
                        MODE_REMOTE: let_go = !tick.remote_cmd;
                        MODE_EITHER: let_go = cool & !tick.remote_cmd;
                        default:     let_go = 1'b0;
                    endcase
                    if (let_go) begin
                        seq_m    = SEQ_OFF;
                        low_m    = 1'b0;
                        fan_on_m = 1'b0;
                    end
                    else if (!tick.fan_feedback) begin
                        // limit minus one wraps in four bits, count saturates
                        trip_at = regs_m.fault_limit - 4'd1;
                        if (count_m != COUNT_MAX)
                            count_m = count_m + 4'd1;
                        if (count_m >= trip_at) begin
                            count_m   = '0;
                            latched_m = 1'b1;
                        end
                    end
                    else if (count_m != '0) begin
                        count_m = count_m - 4'd1;
                    end
                end
                default: ;
            endcase
        end
        else begin
            // Latched fault forces everything off
            seq_m    = SEQ_OFF;
            fan_on_m = 1'b0;
            low_m    = 1'b0;
            high_m   = 1'b0;
        end
        res.high_switch   = high_m;
        res.low_switch    = low_m;
        res.fan_output    = fan_on_m;
        res.fault         = latched_m;
        res.sequence_res  = seq_m;
        res.feedback_echo = tick.fan_feedback;
        return res;
    endfunction

    task automatic check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    // Compare results, predict ticks, track register writes
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            regs_m.control_mode   = RST_CONTROL_MODE;
            regs_m.on_threshold   = RST_ON_THRESHOLD;
            regs_m.release_margin = RST_RELEASE_MARGIN;
            regs_m.fault_limit    = RST_FAULT_LIMIT;
            seq_m      = SEQ_OFF;
            latched_m  = 1'b0;
            count_m    = '0;
            fan_on_m   = 1'b0;
            high_m     = 1'b1;
            low_m      = 1'b0;
            expected_drives.delete();
            pending    = 0;
            fail_count = 0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (expected_drives.size() == 0) begin
                    $error("result transfer with no tick outstanding: m_tdata=%h", m_tdata);
                    fail_count++;
                end
                else begin
                    exp_r = expected_drives.pop_front();
                    got_r = result_t'(m_tdata[$bits(result_t)-1:0]);
                    check_field("high_switch", exp_r.high_switch, got_r.high_switch);
                    check_field("low_switch", exp_r.low_switch, got_r.low_switch);
                    check_field("fan_output", exp_r.fan_output, got_r.fan_output);
                    check_field("fault", exp_r.fault, got_r.fault);
                    check_field("sequence_res", exp_r.sequence_res, got_r.sequence_res);
                    check_field("feedback_echo", exp_r.feedback_echo, got_r.feedback_echo);
                    check_field("m_tdata pad", 0, m_tdata[M_TDATA_W-1]);
                end
            end
            if (s_tvalid && s_tready)
                expected_drives.push_back(
                    next_fan_drives(item_t'(s_tdata[$bits(item_t)-1:0])));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CONTROL_MODE:   regs_m.control_mode   = cfg_data[MODE_W-1:0];
                    REG_ON_THRESHOLD:   regs_m.on_threshold   = cfg_data[TEMP_W-1:0];
                    REG_RELEASE_MARGIN: regs_m.release_margin = cfg_data[MARGIN_W-1:0];
                    REG_FAULT_LIMIT:    regs_m.fault_limit    = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            pending = expected_drives.size();
        end
    end

endmodule

@@ tb/fan_hysteresis_controller_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_hysteresis_controller_top_tb
// Drives temperature ticks and register settings into the fan controller:
// a directed pass over each mode and hysteresis edge, fault counter bursts,
// randomized phases and a closing fault latch, with random gaps and stalls.
// ----------------------------------------------------------------------------
module fan_hysteresis_controller_top_tb;
    import fhc_pkg::*;

    // Mode code with no turn-on or release rule
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    localparam int HOLD_AT      = 460;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 4;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int                     fail_count;
    int                     pending;
    int                     ticks_sent;
    bit                     s_burst;

    always #1 clk = ~clk;

    fan_hysteresis_controller_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fan_hysteresis_controller_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offer one tick after a random gap and hold it until the transfer
    task automatic send_tick(input int temp_v, input logic fb, input logic cmd);
        item_t tick;
        int    gap;
        if (ticks_sent % 50 == 0)
            s_burst = ($urandom_range(0, 2) == 0);
        ticks_sent++;
        gap = s_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick.cell_temp_max = temp_v[TEMP_W-1:0];
        tick.fan_feedback  = fb;
        tick.remote_cmd    = cmd;
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(tick);
        do @(posedge clk); while (!s_tready);
    endtask

    // Stop offering and wait until every result has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic configure(input logic [MODE_W-1:0] mode, input int thr_v,
                             input int margin_v, input int limit_v);
        wait_idle();
        write_reg(REG_CONTROL_MODE, CFG_DATA_W'(mode));
        write_reg(REG_ON_THRESHOLD, thr_v[CFG_DATA_W-1:0]);
        write_reg(REG_RELEASE_MARGIN, CFG_DATA_W'(margin_v[MARGIN_W-1:0]));
        write_reg(REG_FAULT_LIMIT, CFG_DATA_W'(limit_v[LIMIT_W-1:0]));
        cfg_valid <= 1'b0;
    endtask

    function automatic int full_range_temp();
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    // Mostly straddle the turn-on and release points, sometimes anywhere
    function automatic int pick_temp(input int thr_v, input int margin_v);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            return thr_v - margin_v - 6 + int'($urandom_range(0, margin_v + 12));
        else if (sel < 9)
            return int'($urandom_range(0, 1900)) - 400;
        else
            return full_range_temp();
    endfunction

    // Hold the fan running and walk the fault counter up and back to zero
    task automatic run_count_bursts(input int n_bursts, input int max_burst);
        int j;
        int len;
        repeat (15) send_tick(full_range_temp(), 1'b1, 1'b1);
        for (j = 0; j < n_bursts; j++) begin
            len = $urandom_range(1, max_burst);
            repeat (len) send_tick(full_range_temp(), 1'b0, 1'b1);
            repeat (len + 1) send_tick(full_range_temp(), 1'b1, 1'b1);
        end
    endtask

    // Random setting, then ticks with a sticky remote command
    task automatic run_random_phase(input int n_ticks);
        logic [MODE_W-1:0] mode;
        int                thr_v;
        int                margin_v;
        int                limit_v;
        int                fb_off_pct;
        logic              cmd;
        logic              fb;
        int                k;
        case ($urandom_range(0, 9))
            0:       mode = MODE_NONE;
            1, 2, 3: mode = MODE_SELF;
            4, 5, 6: mode = MODE_REMOTE;
            default: mode = MODE_EITHER;
        endcase
        case ($urandom_range(0, 5))
            0:       thr_v = -2048;
            1:       thr_v = 2047;
            2:       thr_v = -400;
            3:       thr_v = 1500;
            default: thr_v = int'($urandom_range(0, 1900)) - 400;
        endcase
        case ($urandom_range(0, 3))
            0:       margin_v = 0;
            1:       margin_v = 255;
            default: margin_v = $urandom_range(0, 255);
        endcase
        // Let feedback drop only where the trip point is far off
        if ($urandom_range(0, 1) == 1) begin
            limit_v = $urandom_range(8, 15);
            if (limit_v == 8)
                limit_v = 0;
            fb_off_pct = 20;
        end
        else begin
            limit_v    = $urandom_range(1, 8);
            fb_off_pct = 0;
        end
        configure(mode, thr_v, margin_v, limit_v);
        cmd = $urandom_range(0, 1);
        for (k = 0; k < n_ticks; k++) begin
            if ($urandom_range(0, 99) < 15)
                cmd = ~cmd;
            fb = ($urandom_range(0, 99) >= fb_off_pct);
            send_tick(pick_temp(thr_v, margin_v), fb, cmd);
        end
    endtask

    // Trip the fault latch and keep ticking into the forced-off state
    task automatic run_fault_phase(input int n_ticks);
        int   k;
        logic cmd;
        configure(MODE_REMOTE, int'($urandom_range(0, 1900)) - 400,
                  $urandom_range(0, 255), $urandom_range(1, 3));
        for (k = 0; k < n_ticks; k++) begin
            cmd = (k < 20) ? 1'b1 : 1'(($urandom_range(0, 1)));
            send_tick(full_range_temp(), ($urandom_range(0, 99) >= 80), cmd);
        end
    endtask

    // Stop the run if it hangs
    initial begin : watchdog
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

    // Accept results with random stalls and one long hold-off
    initial begin : result_sink
        int gap;
        int taken;
        bit m_burst;
        taken    = 0;
        m_burst  = 1'b0;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (taken % 50 == 0)
                m_burst = ($urandom_range(0, 2) == 0);
            gap = m_burst ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            taken++;
            if (taken == HOLD_AT) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        int p;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_CONTROL_MODE;
        cfg_data   = '0;
        ticks_sent = 0;
        s_burst    = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: remote command, counter up once and back
        send_tick(450, 1'b1, 1'b0);
        send_tick(-2048, 1'b0, 1'b1);
        send_tick(2047, 1'b1, 1'b1);
        send_tick(-1, 1'b0, 1'b1);
        send_tick(0, 1'b1, 1'b0);
        send_tick(1500, 1'b1, 1'b1);
        send_tick(-400, 1'b1, 1'b1);
        send_tick(0, 1'b1, 1'b1);

        // Temperature mode: exact turn-on and release edges
        configure(MODE_SELF, 450, 30, 15);
        send_tick(449, 1'b0, 1'b1);
        send_tick(450, 1'b1, 1'b0);
        send_tick(0, 1'b1, 1'b0);
        send_tick(420, 1'b1, 1'b0);
        send_tick(419, 1'b1, 1'b0);
        send_tick(2047, 1'b1, 1'b0);
        send_tick(2047, 1'b1, 1'b0);
        send_tick(-2048, 1'b1, 1'b1);

        // Either mode with zero margin: remote holds the fan on
        configure(MODE_EITHER, 100, 0, 0);
        send_tick(99, 1'b1, 1'b1);
        send_tick(99, 1'b1, 1'b1);
        send_tick(-2048, 1'b1, 1'b1);
        send_tick(100, 1'b1, 1'b0);
        send_tick(99, 1'b1, 1'b0);
        send_tick(100, 1'b1, 1'b0);
        send_tick(-2048, 1'b1, 1'b0);
        send_tick(-2048, 1'b1, 1'b0);

        // Mode without a rule never leaves off; release point below range
        configure(MODE_NONE, -2048, 255, 1);
        send_tick(2047, 1'b0, 1'b1);
        send_tick(-2048, 1'b1, 1'b1);

        configure(MODE_REMOTE, 2047, 255, 15);
        run_count_bursts(8, 12);
        for (p = 0; p < 5; p++)
            run_random_phase(100);
        configure(MODE_REMOTE, -2048, 0, 0);
        run_count_bursts(8, 14);
        for (p = 0; p < 5; p++)
            run_random_phase(100);
        run_fault_phase(80);

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
